// ===== design/sset_pkg.sv =====
// Package for the sorted set unit: shared types and constants.
`default_nettype none

package sset_pkg;

   localparam int DEF_CAPACITY = 16;
   localparam int VALUE_W      = 32;
   localparam int COUNT_W      = 5;

   // Request operation codes
   typedef enum logic [0:0] {
      FUNC_ADD    = 1'b0,
      FUNC_REMOVE = 1'b1
   } func_type;

   // Response status codes
   typedef enum logic [1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_PRESENT  = 2'd1,
      STATUS_FULL     = 2'd2,
      STATUS_REJECTED = 2'd3
   } status_type;

   localparam logic signed [VALUE_W-1:0] MINUS_ONE = -32'sd1;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      logic                        ins;
      logic                        rem;
      logic signed [VALUE_W-1:0]   value;
   } cell_cmd_type;

endpackage

`default_nettype wire

// ===== design/sset_cell.sv =====
// One compare-and-shift cell of the sorted set chain.
`default_nettype none

module sset_cell
   import sset_pkg::*;
(
   input  wire logic                      clock,
   input  wire cell_cmd_type              cmd,
   input  wire logic                      valid,
   input  wire logic                      prev_lt,
   input  wire logic signed [VALUE_W-1:0] prev_entry,
   input  wire logic signed [VALUE_W-1:0] next_entry,
   output logic signed [VALUE_W-1:0]      entry,
   output logic                           lt,
   output logic                           hit
);

   logic signed [VALUE_W-1:0] entry_ff;
   logic signed [VALUE_W-1:0] entry_in;

   // compare against the request value
   assign lt    = valid && (entry_ff < cmd.value);
   assign hit   = valid && (entry_ff == cmd.value);
   assign entry = entry_ff;

   // entries at or above the insert/remove point move
   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins && !lt) begin
         entry_in = prev_lt ? cmd.value : prev_entry;
      end else if (cmd.rem && !lt) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

// ===== design/sorted_set_insert_remove_unit.sv =====
// Response valid is registered: it rises in the cycle after request acceptance.
// One request per cycle while responses are taken; each compare-and-shift cell decides
// and moves its entry in the same cycle, so the chain resolves a whole add or remove at once.
// Reset clears the element count and the response valid; entry contents stay undefined
// and are never read past the count.
// Top level of the sorted set unit: cell chain, count and response register.
`default_nettype none

module sorted_set_insert_remove_unit
   import sset_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
)
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_func,
   input  wire logic signed [VALUE_W-1:0] req_value,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [1:0]                     rsp_status,
   output logic [COUNT_W-1:0]             rsp_count,
   output logic                           rsp_empty_res
);

   localparam int HELD_W = $clog2(CAPACITY + 1);

   logic [HELD_W-1:0]         held_ff, held_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                status_ff, status_in;
   logic [COUNT_W-1:0]        count_ff;
   logic                      empty_ff;

   logic signed [VALUE_W-1:0] entry_vec [CAPACITY];
   logic [CAPACITY-1:0]       lt_vec;
   logic [CAPACITY-1:0]       hit_vec;
   logic [CAPACITY-1:0]       valid_vec;

   logic                      accept;
   logic                      present;
   logic                      full;
   cell_cmd_type              cmd;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign present   = |hit_vec;
   assign full      = (held_ff >= HELD_W'(CAPACITY));

   // decide the operation and its status
   always_comb begin
      cmd.value = req_value;
      cmd.ins   = 1'b0;
      cmd.rem   = 1'b0;
      status_in = STATUS_DONE;
      held_in   = held_ff;
      if (req_func == FUNC_ADD) begin
         if (present) begin
            status_in = STATUS_PRESENT;
         end else if (full) begin
            status_in = STATUS_FULL;
         end else begin
            cmd.ins = accept;
            held_in = held_ff + HELD_W'(1);
         end
      end else begin
         if (req_value == MINUS_ONE) begin
            status_in = STATUS_REJECTED;
         end else if (present) begin
            cmd.rem = accept;
            held_in = held_ff - HELD_W'(1);
         end
      end
   end

   // chain of cells, each talking to its neighbors
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                      prev_lt;
      logic signed [VALUE_W-1:0] prev_entry;
      logic signed [VALUE_W-1:0] next_entry;

      assign valid_vec[i] = (HELD_W'(i) < held_ff);

      if (i == 0) begin : g_first
         assign prev_lt    = 1'b1;
         assign prev_entry = req_value;
      end else begin : g_mid
         assign prev_lt    = lt_vec[i-1];
         assign prev_entry = entry_vec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_entry = entry_vec[i];
      end else begin : g_inner
         assign next_entry = entry_vec[i+1];
      end

      sset_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .valid      (valid_vec[i]),
         .prev_lt    (prev_lt),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .entry      (entry_vec[i]),
         .lt         (lt_vec[i]),
         .hit        (hit_vec[i])
      );
   end

   // count and response valid
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            held_ff <= held_in;
         end
      end
   end

   // response payload; count is reported modulo the count field width
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         count_ff  <= COUNT_W'(held_in);
         empty_ff  <= (held_in == '0);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_count     = count_ff;
   assign rsp_empty_res = empty_ff;

   // checks
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= HELD_W'(CAPACITY))
      else $error("element count above capacity");

   a_hit_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("value matched in more than one cell");

   a_ins_count: assert property (@(posedge clock) disable iff (reset)
      cmd.ins |=> held_ff == $past(held_ff) + HELD_W'(1))
      else $error("insert did not advance count");

   a_rem_count: assert property (@(posedge clock) disable iff (reset)
      cmd.rem |=> held_ff == $past(held_ff) - HELD_W'(1))
      else $error("remove did not reduce count");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == STATUS_FULL |-> !empty_ff)
      else $error("full status reported on empty set");

endmodule

`default_nettype wire
